/* src/cle_pkg.sv */
// ----------------------------------------------------------------------------
// cle_pkg
// shared types and constants of the console line editor
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

	localparam int LINE_MAX_DEF = 64;

	// control key codes
	localparam logic [7:0] KEY_BACKSPACE = 8'h08;
	localparam logic [7:0] KEY_NEWLINE   = 8'h0a;
	localparam logic [7:0] KEY_KILL      = 8'h15;
	localparam logic [7:0] KEY_EOF       = 8'h04;
	localparam logic [7:0] KEY_FLUSH     = 8'h00;

	// utf-8 continuation byte: top bits 10
	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ERASE_RD,
		ST_ERASE_CHK,
		ST_READ,
		ST_SEND,
		ST_EMPTY
	} cle_state_t;

	// one result handed from the sequencer to the output register
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       empty;
	} cle_push_t;

endpackage

`default_nettype wire

/* src/cle_ram.sv */
// ----------------------------------------------------------------------------
// cle_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/cle_ctrl.sv */
// ----------------------------------------------------------------------------
// cle_ctrl
// sequencer with one shared pointer incrementer/decrementer over the line store
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ctrl #(
	parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              raw_mode,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        in_byte,
	input  wire logic              more_pending,
	input  wire logic              out_free,
	output cle_pkg::cle_push_t     push
);

	import cle_pkg::*;

	localparam int AW = $clog2(LINE_MAX);
	localparam int CW = $clog2(LINE_MAX + 1);
	localparam logic [CW-1:0] FULL = CW'(LINE_MAX);

	cle_state_t state_q, state_d;

	logic [CW-1:0] fill_q, ptr_q;
	logic [7:0]    byte_q;
	logic          more_q;

	logic          fill_ld, ptr_ld;
	logic [CW-1:0] fill_val, ptr_val;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// shared pointer unit
	logic          unit_dec;
	logic [CW-1:0] step_sum;

	// decode of the latched byte
	logic is_zero, is_bs, is_kill, is_eof, is_store, send_req, is_full, fill_zero;

	assign is_zero   = (byte_q == KEY_FLUSH);
	assign is_bs     = !raw_mode && (byte_q == KEY_BACKSPACE);
	assign is_kill   = !raw_mode && (byte_q == KEY_KILL);
	assign is_eof    = !raw_mode && (byte_q == KEY_EOF);
	assign is_store  = !is_zero && !is_bs && !is_kill && !is_eof;
	assign fill_zero = (fill_q == '0);
	assign is_full   = (step_sum == FULL);
	assign send_req  = is_zero  ? (!fill_zero && !more_q) :
	                   raw_mode ? !more_q :
	                   (byte_q == KEY_NEWLINE);

	assign unit_dec = ((state_q == ST_DECODE) && is_bs) || (state_q == ST_ERASE_RD) ||
	                  (state_q == ST_ERASE_CHK);
	assign step_sum = unit_dec ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));

	logic is_cont;
	assign is_cont = ((ram_rdata & CONT_MASK) == CONT_TAG);

	cle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_MAX)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q[AW-1:0]),
		.wdata(byte_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				priority if (is_store) begin
					state_d = (send_req || is_full) ? ST_READ : ST_IDLE;
				end else if (is_zero) begin
					state_d = send_req ? ST_READ : ST_IDLE;
				end else if (is_eof) begin
					state_d = fill_zero ? ST_EMPTY : ST_READ;
				end else if (is_bs) begin
					state_d = (!fill_zero && step_sum != '0) ? ST_ERASE_RD : ST_IDLE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ERASE_RD: state_d = ST_ERASE_CHK;
			ST_ERASE_CHK: begin
				state_d = (is_cont && step_sum != '0) ? ST_ERASE_RD : ST_IDLE;
			end
			ST_READ: state_d = ST_SEND;
			ST_SEND: begin
				if (out_free) state_d = (step_sum == fill_q) ? ST_IDLE : ST_READ;
			end
			ST_EMPTY: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		in_ready   = 1'b0;
		fill_ld    = 1'b0;
		fill_val   = step_sum;
		ptr_ld     = 1'b0;
		ptr_val    = step_sum;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = ptr_q[AW-1:0];
		push       = '0;
		push.data  = ram_rdata;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ptr_ld   = in_valid;
				ptr_val  = fill_q;
			end
			ST_DECODE: begin
				priority if (is_store) begin
					ram_we  = 1'b1;
					fill_ld = 1'b1;
					if (send_req || is_full) begin
						ptr_ld  = 1'b1;
						ptr_val = '0;
					end
				end else if (is_zero || is_eof) begin
					ptr_ld  = 1'b1;
					ptr_val = '0;
				end else if (is_bs) begin
					if (!fill_zero) begin
						ptr_ld = 1'b1;
						if (step_sum == '0) begin
							fill_ld  = 1'b1;
							fill_val = '0;
						end
					end
				end else begin
					fill_ld  = 1'b1;
					fill_val = '0;
				end
			end
			ST_ERASE_RD: begin
				ram_re    = 1'b1;
				ram_raddr = step_sum[AW-1:0];
			end
			ST_ERASE_CHK: begin
				if (is_cont) begin
					ptr_ld = 1'b1;
					if (step_sum == '0) begin
						fill_ld  = 1'b1;
						fill_val = '0;
					end
				end else begin
					fill_ld  = 1'b1;
					fill_val = ptr_q;
				end
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_SEND: begin
				if (out_free) begin
					push.valid = 1'b1;
					push.last  = (step_sum == fill_q);
					ptr_ld     = 1'b1;
					if (step_sum == fill_q) begin
						fill_ld  = 1'b1;
						fill_val = '0;
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					push.valid = 1'b1;
					push.data  = 8'h00;
					push.last  = 1'b1;
					push.empty = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (fill_ld) fill_q <= fill_val;
			if (ptr_ld)  ptr_q  <= ptr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= in_byte;
			more_q <= more_pending;
		end
	end

	// a result is only handed over when the output register can take it
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> out_free)
		else $error("result pushed into a busy output register");

	// the line store never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count above line depth");

	// a new byte is only taken while the store has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (fill_q < FULL))
		else $error("byte accepted into a full store");

	// the final byte of a released line empties the store
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.last) |=> (fill_q == '0))
		else $error("store not emptied after release");

	// the backspace walk only reads inside the stored line
	a_erase_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERASE_RD) |-> (ptr_q != '0 && ptr_q <= fill_q))
		else $error("erase walk left the stored line");

endmodule

`default_nettype wire

/* src/console_line_editor_unit.sv */
// ----------------------------------------------------------------------------
// console_line_editor_unit
// keyboard line discipline: cooked editing or raw collection into a line store
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one keyboard byte per transaction, with tuser set when more
//   input is already waiting behind it. m_axis returns released lines, one
//   byte per transaction, oldest first, tlast on the final byte; tuser marks
//   the single empty-line (end of file) transaction of a ctrl-d on an empty line.
//   the user writes raw_mode (cfg_we/cfg_wdata) only while the block is idle; not enforced.
// sequencing
//   a byte that only edits the line passes the decode state, during which
//   s_axis_tready is low. backspace adds an erase read and an erase check state
//   for each byte it examines in front of the erased one. a release passes the
//   read and send states for each line byte, as the line store has a single
//   read port with a registered read.
// reset
//   arst_n clears the fill count, the sequencer and raw_mode (cooked). the
//   line store itself is not cleared: only written entries are ever read.
// stalls
//   results sit in an output register; while it is full and m_axis_tready is
//   low the sequencer holds its place and s_axis_tready stays low until the
//   final byte of the line has been loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor_unit #(
	parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,      // raw_mode
	// keyboard input
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire logic       s_axis_tuser,   // [0] more_pending
	// released line output
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata,   // [7:0] line_byte
	output logic            m_axis_tlast,   // last
	output logic            m_axis_tuser    // [0] empty_line
);

	import cle_pkg::*;

	logic      raw_mode_q;
	logic      out_valid_q;
	logic      out_free;
	cle_push_t push;

	// mode register; the user writes it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
		end else if (cfg_we) begin
			raw_mode_q <= cfg_wdata;
		end
	end

	// output register frees up in the same cycle its transaction completes
	assign out_free = !out_valid_q || m_axis_tready;

	cle_ctrl #(
		.LINE_MAX(LINE_MAX)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.raw_mode    (raw_mode_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.more_pending(s_axis_tuser),
		.out_free    (out_free),
		.push        (push)
	);

	// output register: valid cleared under reset, payload loads with each push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			m_axis_tdata <= push.data;
			m_axis_tlast <= push.last;
			m_axis_tuser <= push.empty;
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire
